>>> rtl/complex_arithmetic_unit_defines.svh
// -----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared concurrent assertion wrappers for the checker.
// -----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Check that holds outside reset only.
`define CAU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("complex_arithmetic_unit: assertion failed");

// Check that also holds across reset.
`define CAU_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("complex_arithmetic_unit: reset assertion failed");

`endif

>>> rtl/cau_pkg.sv
// -----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, opcode and status codes, pipeline record and saturation helper.
// -----------------------------------------------------------------------------
package cau_pkg;

    localparam int W_BITS = 32;            // word width of every operand part
    localparam int F_BITS = 16;            // fraction bits
    localparam int PB     = 2 * W_BITS;    // product width
    localparam int MB     = PB + 1;        // sum of products / magnitude width
    localparam int DB     = PB;            // |B|^2 width
    localparam int QB     = W_BITS + 1;    // quotient bits developed
    localparam int NW     = MB + F_BITS;   // scaled dividend width
    localparam int R0W    = NW - QB;       // dividend bits above the quotient window
    localparam int LW     = W_BITS + 1;    // add / subtract / conjugate width

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_CONJ = 3'd4;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    typedef struct packed {
        logic [W_BITS-1:0] value;
        logic              flag;
    } t_sat;

    // One record per divider step; non-divide results ride along finished.
    typedef struct packed {
        logic              valid;
        logic [2:0]        op;
        logic              dz;
        logic [W_BITS-1:0] lin_re;
        logic [W_BITS-1:0] lin_im;
        logic              lin_flag;
        logic              neg_re;
        logic              neg_im;
        logic              ovf_re;
        logic              ovf_im;
        logic [DB-1:0]     den;
        logic [DB-1:0]     rem_re;
        logic [DB-1:0]     rem_im;
        logic [QB-1:0]     low_re;
        logic [QB-1:0]     low_im;
        logic [QB-1:0]     q_re;
        logic [QB-1:0]     q_im;
    } t_cau_div;

    // Clamp a sign-magnitude value into a signed word.
    function automatic t_sat f_sat(input logic neg, input logic [MB-1:0] mag);
        t_sat          r;
        logic [MB-1:0] lim_neg;
        logic [MB-1:0] lim_pos;
        lim_neg = {{(MB-W_BITS){1'b0}}, 1'b1, {(W_BITS-1){1'b0}}};
        lim_pos = lim_neg - 1'b1;
        r.flag  = 1'b0;
        if (!neg) begin
            if (mag > lim_pos) begin
                r.value = {1'b0, {(W_BITS-1){1'b1}}};
                r.flag  = 1'b1;
            end else begin
                r.value = mag[W_BITS-1:0];
            end
        end else begin
            if (mag > lim_neg) begin
                r.value = {1'b1, {(W_BITS-1){1'b0}}};
                r.flag  = 1'b1;
            end else begin
                r.value = ~mag[W_BITS-1:0] + 1'b1;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/complex_arithmetic_unit.sv
// -----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined add, subtract, multiply, divide and conjugate on Q16.16 operands.
// -----------------------------------------------------------------------------
// Accepts one transaction per clock while the output side keeps up, and
// returns one result per transaction, in order, through 38 register
// stages. The depth is set by the divider: 33 restoring steps, one
// quotient bit per stage, behind four stages of multiply, sum, magnitude
// and setup, plus the output register. Every opcode takes the same path
// so results never reorder. The whole pipeline holds when the output is
// valid and not taken; ready falls only then. Multiply truncates toward
// zero; divide computes A*conj(B)/|B|^2 truncated toward zero, and returns
// zero with status 2 when B is zero. Any part outside the word range is
// clamped with status 1. Opcodes 5 to 7 return zero with status 0.
// -----------------------------------------------------------------------------
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_opcode,
    input  logic signed [W_BITS-1:0] i_a_re,
    input  logic signed [W_BITS-1:0] i_a_im,
    input  logic signed [W_BITS-1:0] i_b_re,
    input  logic signed [W_BITS-1:0] i_b_im,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [W_BITS-1:0] o_res_re,
    output logic signed [W_BITS-1:0] o_res_im,
    output logic [1:0]               o_status
);

    // Global advance: move everything when the output slot is free or taken.
    logic en;

    // Stage 1: products and the linear operations
    logic                 r_s1_valid;
    logic [2:0]           r_s1_op;
    logic signed [PB-1:0] r_s1_p_rr, r_s1_p_ii, r_s1_p_ir, r_s1_p_ri, r_s1_p_dr, r_s1_p_di;
    logic signed [LW-1:0] r_s1_lin_re, r_s1_lin_im, n_s1_lin_re, n_s1_lin_im;

    // Stage 2: sums of products
    logic                 r_s2_valid;
    logic [2:0]           r_s2_op;
    logic signed [MB-1:0] r_s2_val_re, r_s2_val_im, n_s2_val_re, n_s2_val_im;
    logic [DB-1:0]        r_s2_den;

    // Stage 3: sign and magnitude
    logic                 r_s3_valid;
    logic [2:0]           r_s3_op;
    logic                 r_s3_neg_re, r_s3_neg_im;
    logic [MB-1:0]        r_s3_mag_re, r_s3_mag_im, n_s3_mag_re, n_s3_mag_im;
    logic [DB-1:0]        r_s3_den;

    // Stage 4: divider setup and finished non-divide results
    t_cau_div             r_s4, n_s4;
    t_sat                 s4_sat_re, s4_sat_im;
    logic [NW-1:0]        s4_nw_re, s4_nw_im;
    logic [R0W-1:0]       s4_r0_re, s4_r0_im;

    // Divider chain
    t_cau_div             w_div [0:QB];

    // Output register
    logic                 r_out_valid;
    logic [W_BITS-1:0]    r_out_re, r_out_im, n_out_re, n_out_im;
    logic [1:0]           r_out_status, n_out_status;
    t_sat                 out_sat_re, out_sat_im;
    logic [MB-1:0]        out_mag_re, out_mag_im;
    t_cau_div             last;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // ---------------- stage 1 ----------------
    always_comb begin
        case (i_opcode)
            OP_ADD: begin
                n_s1_lin_re = LW'(i_a_re) + LW'(i_b_re);
                n_s1_lin_im = LW'(i_a_im) + LW'(i_b_im);
            end
            OP_SUB: begin
                n_s1_lin_re = LW'(i_a_re) - LW'(i_b_re);
                n_s1_lin_im = LW'(i_a_im) - LW'(i_b_im);
            end
            OP_CONJ: begin
                n_s1_lin_re = LW'(i_a_re);
                n_s1_lin_im = -LW'(i_a_im);
            end
            default: begin
                n_s1_lin_re = '0;
                n_s1_lin_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_in_valid;
            r_s1_op     <= i_opcode;
            r_s1_p_rr   <= i_a_re * i_b_re;
            r_s1_p_ii   <= i_a_im * i_b_im;
            r_s1_p_ir   <= i_a_im * i_b_re;
            r_s1_p_ri   <= i_a_re * i_b_im;
            r_s1_p_dr   <= i_b_re * i_b_re;
            r_s1_p_di   <= i_b_im * i_b_im;
            r_s1_lin_re <= n_s1_lin_re;
            r_s1_lin_im <= n_s1_lin_im;
        end
    end

    // ---------------- stage 2 ----------------
    always_comb begin
        case (r_s1_op)
            OP_MUL: begin
                n_s2_val_re = MB'(r_s1_p_rr) - MB'(r_s1_p_ii);
                n_s2_val_im = MB'(r_s1_p_ir) + MB'(r_s1_p_ri);
            end
            OP_DIV: begin
                n_s2_val_re = MB'(r_s1_p_rr) + MB'(r_s1_p_ii);
                n_s2_val_im = MB'(r_s1_p_ir) - MB'(r_s1_p_ri);
            end
            default: begin
                n_s2_val_re = MB'(r_s1_lin_re);
                n_s2_val_im = MB'(r_s1_lin_im);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid  <= r_s1_valid;
            r_s2_op     <= r_s1_op;
            r_s2_val_re <= n_s2_val_re;
            r_s2_val_im <= n_s2_val_im;
            // squares are never negative, so the sum fits unsigned
            r_s2_den    <= $unsigned(r_s1_p_dr) + $unsigned(r_s1_p_di);
        end
    end

    // ---------------- stage 3 ----------------
    always_comb begin
        n_s3_mag_re = r_s2_val_re[MB-1] ? MB'(-r_s2_val_re) : MB'(r_s2_val_re);
        n_s3_mag_im = r_s2_val_im[MB-1] ? MB'(-r_s2_val_im) : MB'(r_s2_val_im);
        // multiply drops fraction bits on the magnitude: truncate toward zero
        if (r_s2_op == OP_MUL) begin
            n_s3_mag_re = n_s3_mag_re >> F_BITS;
            n_s3_mag_im = n_s3_mag_im >> F_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid  <= r_s2_valid;
            r_s3_op     <= r_s2_op;
            r_s3_neg_re <= r_s2_val_re[MB-1];
            r_s3_neg_im <= r_s2_val_im[MB-1];
            r_s3_mag_re <= n_s3_mag_re;
            r_s3_mag_im <= n_s3_mag_im;
            r_s3_den    <= r_s2_den;
        end
    end

    // ---------------- stage 4 ----------------
    always_comb begin
        s4_sat_re = f_sat(r_s3_neg_re, r_s3_mag_re);
        s4_sat_im = f_sat(r_s3_neg_im, r_s3_mag_im);
        s4_nw_re  = {r_s3_mag_re, {F_BITS{1'b0}}};
        s4_nw_im  = {r_s3_mag_im, {F_BITS{1'b0}}};
        s4_r0_re  = s4_nw_re[NW-1:QB];
        s4_r0_im  = s4_nw_im[NW-1:QB];

        n_s4.valid  = r_s3_valid;
        n_s4.op     = r_s3_op;
        n_s4.dz     = (r_s3_den == '0);
        n_s4.neg_re = r_s3_neg_re;
        n_s4.neg_im = r_s3_neg_im;
        n_s4.den    = r_s3_den;
        // a scaled dividend at or above den * 2^QB overflows the quotient window
        n_s4.ovf_re = {{DB{1'b0}}, s4_r0_re} >= {{R0W{1'b0}}, r_s3_den};
        n_s4.ovf_im = {{DB{1'b0}}, s4_r0_im} >= {{R0W{1'b0}}, r_s3_den};
        n_s4.rem_re = DB'(s4_r0_re);
        n_s4.rem_im = DB'(s4_r0_im);
        n_s4.low_re = s4_nw_re[QB-1:0];
        n_s4.low_im = s4_nw_im[QB-1:0];
        n_s4.q_re   = '0;
        n_s4.q_im   = '0;
        if (r_s3_op <= OP_CONJ) begin
            n_s4.lin_re   = s4_sat_re.value;
            n_s4.lin_im   = s4_sat_im.value;
            n_s4.lin_flag = s4_sat_re.flag | s4_sat_im.flag;
        end else begin
            n_s4.lin_re   = '0;
            n_s4.lin_im   = '0;
            n_s4.lin_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.valid <= 1'b0;
        end else if (en) begin
            r_s4 <= n_s4;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    assign w_div[0] = r_s4;

    for (genvar g = 0; g < QB; g++) begin : g_div
        cau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (w_div[g]),
            .o_stage (w_div[g+1])
        );
    end

    // ---------------- output ----------------
    assign last = w_div[QB];

    always_comb begin
        out_mag_re = last.ovf_re ? '1 : MB'(last.q_re);
        out_mag_im = last.ovf_im ? '1 : MB'(last.q_im);
        out_sat_re = f_sat(last.neg_re, out_mag_re);
        out_sat_im = f_sat(last.neg_im, out_mag_im);
        if (last.op == OP_DIV) begin
            if (last.dz) begin
                n_out_re     = '0;
                n_out_im     = '0;
                n_out_status = ST_DZ;
            end else begin
                n_out_re     = out_sat_re.value;
                n_out_im     = out_sat_im.value;
                n_out_status = (out_sat_re.flag | out_sat_im.flag) ? ST_SAT : ST_OK;
            end
        end else begin
            n_out_re     = last.lin_re;
            n_out_im     = last.lin_im;
            n_out_status = last.lin_flag ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid  <= last.valid;
            r_out_re     <= n_out_re;
            r_out_im     <= n_out_im;
            r_out_status <= n_out_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res_re    = r_out_re;
    assign o_res_im    = r_out_im;
    assign o_status    = r_out_status;

endmodule

>>> rtl/cau_div_step.sv
// -----------------------------------------------------------------------------
// Divider step
// One restoring-division bit for the real and imaginary quotients.
// -----------------------------------------------------------------------------
module cau_div_step
    import cau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_cau_div i_stage,
    output t_cau_div o_stage
);

    t_cau_div      r_stage;
    t_cau_div      n_stage;
    logic [DB:0]   tr_re, tr_im, df_re, df_im;
    logic          ge_re, ge_im;

    always_comb begin
        tr_re = {i_stage.rem_re, i_stage.low_re[QB-1]};
        tr_im = {i_stage.rem_im, i_stage.low_im[QB-1]};
        df_re = tr_re - {1'b0, i_stage.den};
        df_im = tr_im - {1'b0, i_stage.den};
        ge_re = tr_re >= {1'b0, i_stage.den};
        ge_im = tr_im >= {1'b0, i_stage.den};

        n_stage        = i_stage;
        n_stage.rem_re = ge_re ? df_re[DB-1:0] : tr_re[DB-1:0];
        n_stage.rem_im = ge_im ? df_im[DB-1:0] : tr_im[DB-1:0];
        n_stage.q_re   = {i_stage.q_re[QB-2:0], ge_re};
        n_stage.q_im   = {i_stage.q_im[QB-2:0], ge_im};
        n_stage.low_re = {i_stage.low_re[QB-2:0], 1'b0};
        n_stage.low_im = {i_stage.low_im[QB-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> rtl/cau_checker.sv
// -----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level assertions, bound to the top level.
// -----------------------------------------------------------------------------
`include "complex_arithmetic_unit_defines.svh"

module cau_checker
    import cau_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [W_BITS-1:0] o_res_re,
    input logic [W_BITS-1:0] o_res_im,
    input logic [1:0]        o_status
);

    logic                  res_zero;
    logic                  re_at_limit;
    logic                  im_at_limit;
    logic [2*W_BITS+1:0]   res_bus;

    assign res_zero    = (o_res_re == '0) && (o_res_im == '0);
    assign re_at_limit = (o_res_re[W_BITS-2:0] == '1) || (o_res_re[W_BITS-2:0] == '0);
    assign im_at_limit = (o_res_im[W_BITS-2:0] == '1) || (o_res_im[W_BITS-2:0] == '0);
    assign res_bus     = {o_res_re, o_res_im, o_status};

    // reset drops any pending result
    `CAU_ASSERT_ALWAYS(a_rst_clears, !i_rst_n |=> !o_out_valid)

    // input side stalls only while a result waits unclaimed
    `CAU_ASSERT(a_ready_rule, o_in_ready == (!o_out_valid || i_out_ready))

    // divide by zero returns zero in both parts
    `CAU_ASSERT(a_dz_zero, (o_out_valid && o_status == ST_DZ) |-> res_zero)

    // a saturated result has at least one part whose bits below the sign are all equal, as at a word limit
    `CAU_ASSERT(a_sat_limit, (o_out_valid && o_status == ST_SAT) |-> (re_at_limit || im_at_limit))

    // a stalled result holds
    `CAU_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(res_bus)))

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
